// ===== rtl/sgb_pkg.sv =====
package sgb_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int MaxRadius = 3;
  localparam int Depth     = MaxWidth * MaxHeight;
  localparam int AddrW     = $clog2(Depth);

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_W0     = 3'd3;
  localparam logic [2:0] REG_W1     = 3'd4;
  localparam logic [2:0] REG_W2     = 3'd5;
  localparam logic [2:0] REG_W3     = 3'd6;

  localparam logic RESULT_PIXEL = 1'b0;
  localparam logic RESULT_DONE  = 1'b1;
endpackage

// ===== rtl/sgb_ram.sv =====
module sgb_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sgb_mac.sv =====
// One channel lane of the shared multiply-accumulate unit.
module sgb_mac (
  input  logic        clk,
  input  logic        clear,
  input  logic        en,
  input  logic [7:0]  pix,
  input  logic [15:0] wt,
  output logic [7:0]  sat
);
  logic [26:0] acc_r;
  logic [23:0] prod;

  assign prod = pix * wt;

  always_ff @(posedge clk) begin
    if (clear) acc_r <= '0;
    else if (en) acc_r <= acc_r + 27'(prod);
  end

  // truncate by 16 and clamp
  assign sat = (acc_r[26:24] != 3'd0) ? 8'hff : acc_r[23:16];
endmodule

// ===== rtl/separable_gaussian_blur.sv =====
// Separable Gaussian blur, clamp-to-edge, for RGBA images up to 64x64.
// Write items (func 0) store one pixel and give no result; read items
// (func 2) return the stored pixel, through the RAM's read register and a
// pending flag, as result_kind 0. A run item (func 1) blurs the image in
// place: a horizontal pass into a temp store, then a vertical pass back.
// Each output pixel sums its 2*radius+1 taps on the shared
// multiply-accumulate unit, drains for memory latency and is written back;
// after the run one result_kind 1 item with zero channels is produced.
// Radius 0 finishes at once. Input stalls while a run walks the image, a
// read is pending or a result waits unread. Weights are Q0.16, sums
// truncated and saturated at 255. Both stores are undefined until written.
module separable_gaussian_blur (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_pixel_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_result_kind,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sgb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAP   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;

  logic [6:0]  width_r, height_r;
  logic [1:0]  radius_r;
  logic [15:0] w0_r, w1_r, w2_r, w3_r;

  logic [2:0]  state_r;
  logic        vert_r;
  logic [5:0]  col_r, row_r;
  logic [3:0]  tap_r;
  logic [1:0]  pipe_r;
  logic        rd_pend_r;
  logic        out_valid_r;
  logic [31:0] out_pix_r;
  logic        out_kind_r;

  logic [5:0]  wl, hl;
  logic [6:0]  wc, hc;
  logic        accept;
  logic signed [7:0] pos;
  logic [5:0]  lim, cpos, nx, ny;
  logic [AddrW-1:0] tap_addr, cur_addr;
  logic [11:0] tap_full, cur_full;
  logic [1:0]  tap_dist;
  logic [15:0] wt;
  logic [31:0] img_rd, tmp_rd, src;
  logic [7:0]  ch [4];
  logic        mac_clear, mac_en;
  logic        img_we;
  logic [AddrW-1:0] img_wa, img_ra;
  logic [31:0] img_wd, res;
  logic [3:0]  ntaps;

  assign wc = (width_r == 7'd0) ? 7'd1 : ((width_r > 7'(MaxWidth)) ? 7'(MaxWidth) : width_r);
  assign hc = (height_r == 7'd0) ? 7'd1
              : ((height_r > 7'(MaxHeight)) ? 7'(MaxHeight) : height_r);
  assign wl = 6'(wc - 7'd1);
  assign hl = 6'(hc - 7'd1);
  assign ntaps = {1'b0, radius_r, 1'b0};

  // hold input while a result is pending so reads never overwrite it
  assign in_stall = (state_r != S_IDLE) || out_valid_r || rd_pend_r;
  assign accept = in_valid && !in_stall;

  // tap position with edge clamp
  always_comb begin
    cpos = vert_r ? row_r : col_r;
    lim  = vert_r ? hl : wl;
    pos  = $signed({2'b00, cpos}) + $signed({4'b0000, tap_r}) - $signed({6'b0, radius_r});
    if (pos < 0) nx = 6'd0;
    else if (pos > $signed({2'b00, lim})) nx = lim;
    else nx = pos[5:0];
    ny = vert_r ? nx : row_r;
    tap_full = 12'(ny * wc) + 12'(vert_r ? col_r : nx);
    cur_full = 12'(row_r * wc) + 12'(col_r);
    tap_addr = tap_full[AddrW-1:0];
    cur_addr = cur_full[AddrW-1:0];
  end

  // weight for the tap whose data arrives now (issued in the previous cycle)
  logic [3:0] tap_d1_r;
  logic       en_d1_r;
  always_comb begin
    logic [3:0] d;
    d = (tap_d1_r >= {2'b00, radius_r}) ? tap_d1_r - {2'b00, radius_r}
                                        : {2'b00, radius_r} - tap_d1_r;
    tap_dist = d[1:0];
    case (tap_dist)
      2'd0: wt = w0_r;
      2'd1: wt = w1_r;
      2'd2: wt = w2_r;
      default: wt = w3_r;
    endcase
  end

  assign src = vert_r ? tmp_rd : img_rd;
  assign mac_en = en_d1_r;
  assign mac_clear = (state_r == S_IDLE) || (state_r == S_WB);

  for (genvar c = 0; c < 4; c++) begin : g_lane
    sgb_mac u_mac (
      .clk(clk), .clear(mac_clear), .en(mac_en),
      .pix(src[8*c +: 8]), .wt(wt), .sat(ch[c])
    );
  end
  assign res = {ch[3], ch[2], ch[1], ch[0]};

  always_comb begin
    img_we = 1'b0;
    img_wa = in_pixel_index[AddrW-1:0];
    img_wd = {in_alpha, in_blue, in_green, in_red};
    if (accept && in_func == FUNC_WRITE) img_we = 1'b1;
    if (state_r == S_WB && vert_r) begin
      img_we = 1'b1;
      img_wa = cur_addr;
      img_wd = res;
    end
    img_ra = (state_r == S_IDLE) ? in_pixel_index[AddrW-1:0] : tap_addr;
  end

  sgb_ram #(.Width(32), .Depth(Depth)) u_img (
    .clk(clk), .we(img_we), .waddr(img_wa), .wdata(img_wd),
    .raddr(img_ra), .rdata(img_rd)
  );

  sgb_ram #(.Width(32), .Depth(Depth)) u_tmp (
    .clk(clk), .we(state_r == S_WB && !vert_r), .waddr(cur_addr), .wdata(res),
    .raddr(tap_addr), .rdata(tmp_rd)
  );

  always_ff @(posedge clk) begin
    tap_d1_r <= tap_r;
    if (!rst_n) begin
      width_r <= 7'd64; height_r <= 7'd64; radius_r <= 2'd1;
      w0_r <= 16'd29614; w1_r <= 16'd17961; w2_r <= 16'd0; w3_r <= 16'd0;
      state_r <= S_IDLE; vert_r <= 1'b0; col_r <= '0; row_r <= '0; tap_r <= '0;
      pipe_r <= '0; rd_pend_r <= 1'b0; out_valid_r <= 1'b0;
      en_d1_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data[6:0];
          REG_HEIGHT: height_r <= cfg_data[6:0];
          REG_RADIUS: radius_r <= cfg_data[1:0];
          REG_W0:     w0_r <= cfg_data;
          REG_W1:     w1_r <= cfg_data;
          REG_W2:     w2_r <= cfg_data;
          REG_W3:     w3_r <= cfg_data;
          default: ;
        endcase
      end
      en_d1_r <= (state_r == S_TAP);
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      // a read result lands in the RAM's output register in the cycle after the address goes in
      rd_pend_r <= 1'b0;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= RESULT_PIXEL;
        out_pix_r   <= img_rd;
      end
      unique case (state_r)
        S_IDLE: if (accept) begin
          if (in_func == FUNC_READ) begin
            rd_pend_r <= 1'b1;
          end else if (in_func == FUNC_RUN) begin
            if (radius_r == 2'd0) begin
              out_valid_r <= 1'b1; out_kind_r <= RESULT_DONE; out_pix_r <= '0;
            end else begin
              state_r <= S_TAP; vert_r <= 1'b0; col_r <= '0; row_r <= '0; tap_r <= '0;
            end
          end
        end
        S_TAP: begin
          if (tap_r == ntaps) begin
            state_r <= S_DRAIN; pipe_r <= '0;
          end else tap_r <= tap_r + 4'd1;
        end
        S_DRAIN: begin
          pipe_r <= pipe_r + 2'd1;
          if (pipe_r == 2'd2) state_r <= S_WB;
        end
        S_WB: begin
          tap_r <= '0;
          state_r <= S_TAP;
          if (col_r != wl) col_r <= col_r + 6'd1;
          else begin
            col_r <= '0;
            if (row_r != hl) row_r <= row_r + 6'd1;
            else begin
              row_r <= '0;
              if (vert_r) begin
                state_r <= S_IDLE; vert_r <= 1'b0;
                out_valid_r <= 1'b1; out_kind_r <= RESULT_DONE; out_pix_r <= '0;
              end else vert_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r[7:0];
  assign out_green = out_pix_r[15:8];
  assign out_blue  = out_pix_r[23:16];
  assign out_alpha = out_pix_r[31:24];
  assign out_result_kind = out_kind_r;
endmodule

// ===== rtl/sgb_checker.sv =====
module sgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_result_kind,
  input logic [7:0] out_red
);
  import sgb_pkg::*;

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while a result waits");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RESULT_DONE |-> out_red == 8'd0)
    else $error("run result carries data");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_WRITE && !out_valid |=> !out_valid)
    else $error("write produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

bind separable_gaussian_blur sgb_checker u_sgb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_func(in_func), .out_valid(out_valid), .out_stall(out_stall),
  .out_result_kind(out_result_kind), .out_red(out_red)
);

// ===== sim/tb_separable_gaussian_blur.sv =====
module tb_separable_gaussian_blur;
  timeunit 1ns;
  timeprecision 1ps;
  import sgb_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam logic [1:0] FuncIgnored = 2'd3;

  // One pixel as the block packs it: red in the low byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct {
    rgba_t pixel;
    logic  kind;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [11:0] in_pixel_index;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic [7:0]  in_alpha;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_result_kind;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  separable_gaussian_blur DUT (.*);

  // Shadow of the configuration registers, at their register widths.
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  logic [1:0]  radius_reg;
  logic [15:0] tap_weights [4];

  // Own copy of the two stores; track which image pixels were ever written.
  rgba_t image_mem [Depth];
  rgba_t hpass_mem [Depth];
  bit    pixel_written [Depth];

  pixel_result_t expected_pixels [$];
  int errors;
  int cycles;
  int burst_left;
  int stall_left;
  bit quiet_sender;   // no gaps between items
  bit quiet_receiver; // never stall results

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: stall in runs of random length unless quiet.
  always @(posedge clk) begin
    if (quiet_receiver) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result, kind", out_result_kind, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", out_result_kind, want.kind);
        if (out_red !== want.pixel.red)     report_mismatch("red", out_red, want.pixel.red);
        if (out_green !== want.pixel.green)
          report_mismatch("green", out_green, want.pixel.green);
        if (out_blue !== want.pixel.blue)   report_mismatch("blue", out_blue, want.pixel.blue);
        if (out_alpha !== want.pixel.alpha)
          report_mismatch("alpha", out_alpha, want.pixel.alpha);
      end
    end
  end

  // Effective sizes after the block's clamping.
  function automatic int eff_width();
    return (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : (height_reg > MaxHeight) ? MaxHeight : int'(height_reg);
  endfunction

  // One filtered pixel along a row or a column, edges clamped.
  function automatic rgba_t filter_tap_line(bit vertical, int x, int y, int w, int lim, int rad);
    logic [31:0] acc [4];
    rgba_t src;
    rgba_t result;
    logic [31:0] level;
    int nx;
    int ny;
    for (int c = 0; c < 4; c++) acc[c] = '0;
    for (int k = -rad; k <= rad; k++) begin
      nx = x;
      ny = y;
      if (vertical) ny = (y + k < 0) ? 0 : (y + k > lim) ? lim : y + k;
      else nx = (x + k < 0) ? 0 : (x + k > lim) ? lim : x + k;
      src = vertical ? hpass_mem[(ny * w + nx) % Depth] : image_mem[(ny * w + nx) % Depth];
      for (int c = 0; c < 4; c++)
        acc[c] += 32'(src[8*c +: 8]) * 32'(tap_weights[k < 0 ? -k : k]);
    end
    for (int c = 0; c < 4; c++) begin
      level = acc[c] >> 16;
      result[8*c +: 8] = (level > 255) ? 8'hFF : level[7:0];
    end
    return result;
  endfunction

  function automatic void blur_image();
    int w;
    int h;
    int rad;
    w   = eff_width();
    h   = eff_height();
    rad = radius_reg;
    if (rad == 0) return;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        hpass_mem[y * w + x] = filter_tap_line(1'b0, x, y, w, w - 1, rad);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        image_mem[y * w + x] = filter_tap_line(1'b1, x, y, w, h - 1, rad);
  endfunction

  // Work out the result an accepted item causes.
  function automatic void predict_item(logic [1:0] func, logic [11:0] idx, rgba_t px);
    pixel_result_t res;
    case (func)
      FUNC_WRITE: begin
        image_mem[idx]     = px;
        pixel_written[idx] = 1'b1;
      end
      FUNC_RUN: begin
        blur_image();
        res.pixel = '0;
        res.kind  = RESULT_DONE;
        expected_pixels.push_back(res);
      end
      FUNC_READ: begin
        res.pixel = image_mem[idx];
        res.kind  = RESULT_PIXEL;
        expected_pixels.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Send one item; open a new burst after a random gap when the last one ran out.
  task automatic send_item(logic [1:0] func, logic [11:0] idx, rgba_t px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!quiet_sender) begin
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_func        <= func;
    in_pixel_index <= idx;
    in_red         <= px.red;
    in_green       <= px.green;
    in_blue        <= px.blue;
    in_alpha       <= px.alpha;
    do @(posedge clk); while (in_stall);
    predict_item(func, idx, px);
  endtask

  task automatic write_pixel(int idx, rgba_t px);
    send_item(FUNC_WRITE, idx[11:0], px);
  endtask

  task automatic read_pixel(int idx);
    send_item(FUNC_READ, idx[11:0], rgba_t'($urandom));
  endtask

  task automatic run_blur_item();
    send_item(FUNC_RUN, 12'($urandom), rgba_t'($urandom));
  endtask

  // Drop valid, wait until every result is in, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Only call while idle.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg  = data[6:0];
      REG_HEIGHT: height_reg = data[6:0];
      REG_RADIUS: radius_reg = data[1:0];
      REG_W0:     tap_weights[0] = data;
      REG_W1:     tap_weights[1] = data;
      REG_W2:     tap_weights[2] = data;
      REG_W3:     tap_weights[3] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_shape(int w, int h, int rad);
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_RADIUS, 16'(rad));
  endtask

  task automatic set_weights(int w0, int w1, int w2, int w3);
    write_reg(REG_W0, 16'(w0));
    write_reg(REG_W1, 16'(w1));
    write_reg(REG_W2, 16'(w2));
    write_reg(REG_W3, 16'(w3));
  endtask

  // Fill the whole active image so a run never touches an unwritten pixel.
  task automatic fill_image();
    for (int i = 0; i < eff_width() * eff_height(); i++) write_pixel(i, rgba_t'($urandom));
  endtask

  // Extremes of the pixel fields, every function code, the ignored code, reads after a run.
  task automatic test_directed();
    set_shape(4, 3, 2);
    set_weights(20000, 12000, 8000, 0);
    write_pixel(0, 32'h00000000);
    write_pixel(1, 32'hFFFFFFFF);
    write_pixel(2, 32'hA5A5A5A5);
    write_pixel(3, 32'h5A5A5A5A);
    for (int i = 4; i < 12; i++) write_pixel(i, rgba_t'($urandom));
    read_pixel(0);
    read_pixel(1);
    send_item(FuncIgnored, 12'd5, 32'hDEADBEEF); // unused code: ignored
    read_pixel(5);
    run_blur_item();
    read_pixel(0);
    read_pixel(1);
    read_pixel(6);
    read_pixel(11);
    drain();
  endtask

  // Radius zero must leave the image as it was and still report done.
  task automatic test_radius_zero();
    set_shape(3, 2, 0);
    fill_image();
    run_blur_item();
    for (int i = 0; i < 6; i++) read_pixel(i);
    drain();
  endtask

  // Full-scale weights push channels into saturation; width zero is taken as one.
  task automatic test_saturation();
    set_shape(0, 5, 3);
    set_weights(65535, 65535, 65535, 65535);
    fill_image();
    write_pixel(2, 32'hFFFFFFFF);
    run_blur_item();
    for (int i = 0; i < 5; i++) read_pixel(i);
    drain();
  endtask

  // Widest rows at the reset weights, then oversize width at the widest radius and
  // oversize height at radius two, all inside the 256 pixels written here.
  task automatic test_max_sizes();
    set_shape(64, 4, 1);
    set_weights(29614, 17961, 0, 0);
    fill_image();
    write_pixel(255, 32'hFFFFFFFF);
    run_blur_item();
    for (int i = 0; i < 20; i++) read_pixel($urandom_range(0, 255));
    read_pixel(255);
    drain();
    set_shape(127, 4, 3);
    set_weights(20960, 15200, 5800, 1500);
    run_blur_item();
    for (int i = 0; i < 10; i++) read_pixel($urandom_range(0, 255));
    drain();
    set_shape(3, 127, 2);
    run_blur_item();
    for (int i = 0; i < 10; i++) read_pixel($urandom_range(0, 191));
    drain();
  endtask

  // Phases of random small shapes: fill, random traffic, run, read back.
  task automatic test_random_phases();
    int sent;
    int w;
    int h;
    int n;
    int idx;
    sent = 0;
    while (sent < 350) begin
      quiet_sender   = ($urandom_range(0, 4) == 0);
      quiet_receiver = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      set_shape(w, h, $urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) begin
        set_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        set_weights($urandom_range(16000, 30000), $urandom_range(8000, 18000),
                    $urandom_range(0, 8000), $urandom_range(0, 3000));
      end
      fill_image();
      sent += w * h;
      n = $urandom_range(5, 25);
      for (int i = 0; i < n; i++) begin
        idx = $urandom_range(0, w * h - 1);
        case ($urandom_range(0, 9))
          0: send_item(FuncIgnored, 12'($urandom), rgba_t'($urandom));
          1, 2, 3: begin
            write_pixel(idx, rgba_t'($urandom));
            sent++;
          end
          default: begin
            read_pixel(idx);
            sent++;
          end
        endcase
      end
      run_blur_item();
      n = $urandom_range(2, 10);
      for (int i = 0; i < n; i++) read_pixel($urandom_range(0, w * h - 1));
      sent += n + 1;
      drain();
    end
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_WRITE;
    in_pixel_index <= '0;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    in_alpha       <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_WIDTH;
    cfg_data       <= '0;
    errors         = 0;
    burst_left     = 0;
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
    // Reset values of the registers.
    width_reg      = 7'd64;
    height_reg     = 7'd64;
    radius_reg     = 2'd1;
    tap_weights[0] = 16'd29614;
    tap_weights[1] = 16'd17961;
    tap_weights[2] = 16'd0;
    tap_weights[3] = 16'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_max_sizes();
    test_directed();
    test_radius_zero();
    test_saturation();
    test_random_phases();
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
